/* rtl/rv64im_execute_unit_macros.svh */
// Assertion macros shared by the execute unit RTL.
// Each check samples on the rising edge of clk.
`ifndef RV64IM_EXECUTE_UNIT_MACROS_SVH
`define RV64IM_EXECUTE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RV64IM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define RV64IM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RV64IM_ASSERT(lbl, prop, msg)
`define RV64IM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/rv64ex_pkg.sv */
`timescale 1ns / 1ps
package rv64ex_pkg;

	// major opcodes, instruction bits [6:2]
	localparam logic [4:0] OP_REG    = 5'b01100;
	localparam logic [4:0] OP_REG32  = 5'b01110;
	localparam logic [4:0] OP_IMM    = 5'b00100;
	localparam logic [4:0] OP_IMM32  = 5'b00110;
	localparam logic [4:0] OP_LOAD   = 5'b00000;
	localparam logic [4:0] OP_STORE  = 5'b01000;
	localparam logic [4:0] OP_BRANCH = 5'b11000;
	localparam logic [4:0] OP_AUIPC  = 5'b00101;
	localparam logic [4:0] OP_LUI    = 5'b01101;
	localparam logic [4:0] OP_JAL    = 5'b11011;
	localparam logic [4:0] OP_JALR   = 5'b11001;
	localparam logic [4:0] OP_SYSTEM = 5'b11100;

	localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;
	localparam logic [4:0]  REG_A0      = 5'd10;

	localparam logic [1:0] MEM_NONE  = 2'd0;
	localparam logic [1:0] MEM_LOAD  = 2'd1;
	localparam logic [1:0] MEM_STORE = 2'd2;

	localparam logic [1:0] ST_NORMAL  = 2'd0;
	localparam logic [1:0] ST_HALT    = 2'd1;
	localparam logic [1:0] ST_ILLEGAL = 2'd2;

	// multiply/divide unit operations
	localparam logic [1:0] MD_MUL = 2'd0;
	localparam logic [1:0] MD_DIV = 2'd1;
	localparam logic [1:0] MD_REM = 2'd2;

	typedef struct packed {
		logic        command;
		logic [31:0] instruction;
		logic [63:0] pc;
		logic [63:0] load_data;
	} in_t;

	typedef struct packed {
		logic [63:0] next_pc;
		logic [1:0]  mem_op;
		logic [63:0] mem_addr;
		logic [1:0]  mem_size;
		logic [63:0] store_data;
		logic [1:0]  status;
		logic [63:0] halt_code;
		logic        wb_valid;
		logic [4:0]  wb_index;
		logic [63:0] wb_value;
	} out_t;

	typedef struct packed {
		logic        start;
		logic [1:0]  op;
		logic        sgn;
		logic [63:0] a;
		logic [63:0] b;
	} md_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} md_rsp_t;

	typedef struct packed {
		logic       valid;
		logic [4:0] dest;
		logic [1:0] size;
		logic       sgn;
	} pend_t;

	typedef struct packed {
		out_t    out;
		md_req_t md;
		logic    word;
		logic    pend_wr;
		pend_t   pend_nxt;
	} exec_t;

	function automatic logic [63:0] sx32(input logic [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

endpackage

/* rtl/rv64im_execute_unit.sv */
`timescale 1ns / 1ps
// RV64IM execute unit.
// in channel (in_valid/in_ready/in_data): one instruction with its pc, or a
// load-return item carrying the raw memory data for the outstanding load.
// out channel (out_valid/out_ready/out_data): exactly one result per item:
// next pc, memory request, status, halt code and register write-back.
// An item is decoded and its operands read from the register file memory
// (synchronous read); the result is then placed in the output register and
// written back. Mul forms build three 32x32 partial products on one
// multiplier; div and rem forms use the one-bit-per-cycle restoring
// divider. One item is in flight at a time.
// The next item is taken while a result waits in the output register; if
// the receiver stalls, the following item completes and waits until the
// output register frees, holding in_ready low meanwhile.
// Reset clears the register file (via per-entry written flags), the
// pending-load record and all handshake state; no clearing pass is needed.
module rv64im_execute_unit import rv64ex_pkg::*; #(
	parameter int REG_COUNT = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_MD   = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t      st_q;
	in_t         item_q;
	out_t        res_q, out_q, fin_out;
	pend_t       pend_q;
	exec_t       ex;
	md_req_t     md_req;
	md_rsp_t     md_rsp;
	logic        word_q, out_valid_q, accept, rf_we, load_out;
	logic [4:0]  ra_addr;
	logic [63:0] ra_data, rb_data;

	assign accept   = in_valid && in_ready;
	assign in_ready = (st_q == S_IDLE);
	assign ra_addr  = (in_data.instruction == INSN_EBREAK) ? REG_A0 : in_data.instruction[19:15];

	rv64ex_regfile #(.REG_COUNT(REG_COUNT)) u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.ren     (accept),
		.ra_addr (ra_addr),
		.rb_addr (in_data.instruction[24:20]),
		.ra_data (ra_data),
		.rb_data (rb_data),
		.we      (rf_we),
		.waddr   (fin_out.wb_index),
		.wdata   (fin_out.wb_value)
	);

	rv64ex_alu u_alu (
		.item (item_q),
		.pend (pend_q),
		.a    (ra_data),
		.b    (rb_data),
		.ex   (ex)
	);

	always_comb begin
		md_req       = ex.md;
		md_req.start = ex.md.start && (st_q == S_EXEC);
	end

	rv64ex_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	// drop writes to x0 and to registers that are not implemented
	always_comb begin
		fin_out = res_q;
		if (!(res_q.wb_valid && res_q.wb_index != 5'd0
		      && {1'b0, res_q.wb_index} < 6'(REG_COUNT))) begin
			fin_out.wb_valid = 1'b0;
			fin_out.wb_index = '0;
			fin_out.wb_value = '0;
		end
	end

	assign load_out = (st_q == S_FIN) && (!out_valid_q || out_ready);
	assign rf_we    = load_out && fin_out.wb_valid;

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
		if (st_q == S_EXEC) begin
			res_q  <= ex.out;
			word_q <= ex.word;
		end else if (st_q == S_MD && md_rsp.done) begin
			res_q.wb_value <= word_q ? sx32(md_rsp.result) : md_rsp.result;
		end
		if (load_out) begin
			out_q <= fin_out;
		end
	end

	// sequencing, pending load and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (accept) st_q <= S_EXEC;
				end
				S_EXEC: begin
					if (ex.pend_wr) pend_q <= ex.pend_nxt;
					st_q <= ex.md.start ? S_MD : S_FIN;
				end
				S_MD: begin
					if (md_rsp.done) st_q <= S_FIN;
				end
				S_FIN: begin
					if (load_out) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`include "rv64im_execute_unit_macros.svh"
	`RV64IM_ASSERT(a_md_entry, (st_q == S_MD) |-> ($past(st_q) == S_EXEC || $past(st_q) == S_MD), "multicycle state entered out of order")
	`RV64IM_ASSERT(a_done_in_md, md_rsp.done |-> (st_q == S_MD), "muldiv result outside wait state")
	`RV64IM_ASSERT(a_wb_shown, rf_we |=> out_valid_q && out_data.wb_valid, "write-back not reported")
	`RV64IM_ASSERT_ALWAYS(a_no_x0_write, rf_we |-> (fin_out.wb_index != 5'd0), "write to x0")

endmodule

/* rtl/rv64ex_regfile.sv */
`timescale 1ns / 1ps
module rv64ex_regfile import rv64ex_pkg::*; #(
	parameter int REG_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ren,
	input  logic [4:0]  ra_addr,
	input  logic [4:0]  rb_addr,
	output logic [63:0] ra_data,
	output logic [63:0] rb_data,
	input  logic        we,
	input  logic [4:0]  waddr,
	input  logic [63:0] wdata
);

	localparam int AW = $clog2(REG_COUNT);

	logic [63:0]          mem [REG_COUNT];
	logic [REG_COUNT-1:0] valid_q;
	logic [63:0]          ra_q, rb_q;
	logic                 ra_ok_q, rb_ok_q;
	logic                 ra_in, rb_in, w_in;

	// x0 and registers beyond the implemented count read as zero
	assign ra_in = (ra_addr != 5'd0) && ({1'b0, ra_addr} < 6'(REG_COUNT));
	assign rb_in = (rb_addr != 5'd0) && ({1'b0, rb_addr} < 6'(REG_COUNT));
	assign w_in  = (waddr != 5'd0) && ({1'b0, waddr} < 6'(REG_COUNT));

	// storage array, synchronous read
	always_ff @(posedge clk) begin
		if (we && w_in) begin
			mem[waddr[AW-1:0]] <= wdata;
		end
		if (ren) begin
			ra_q <= mem[ra_addr[AW-1:0]];
			rb_q <= mem[rb_addr[AW-1:0]];
		end
	end

	// written flags stand in for the all-zero reset contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ra_ok_q <= 1'b0;
			rb_ok_q <= 1'b0;
		end else begin
			if (we && w_in) begin
				valid_q[waddr[AW-1:0]] <= 1'b1;
			end
			if (ren) begin
				ra_ok_q <= ra_in && valid_q[ra_addr[AW-1:0]];
				rb_ok_q <= rb_in && valid_q[rb_addr[AW-1:0]];
			end
		end
	end

	assign ra_data = ra_ok_q ? ra_q : 64'd0;
	assign rb_data = rb_ok_q ? rb_q : 64'd0;

endmodule

/* rtl/rv64ex_muldiv.sv */
`timescale 1ns / 1ps
module rv64ex_muldiv import rv64ex_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	logic        busy_q, is_mul_q, is_rem_q, neg_q_q, neg_r_q, zero_q, done_q;
	logic [6:0]  cnt_q;
	logic [63:0] x_q, y_q, acc_q, a_q, res_q;
	logic [63:0] rem_q, quo_q, div_q;
	logic [31:0] mop_a, mop_b;
	logic [63:0] prod;
	logic [64:0] trial;
	logic        na, nb;
	logic [63:0] ua, ub;
	logic [63:0] q_fix, r_fix;

	assign na = req.sgn && req.a[63];
	assign nb = req.sgn && req.b[63];
	assign ua = na ? (64'd0 - req.a) : req.a;
	assign ub = nb ? (64'd0 - req.b) : req.b;

	// one 32x32 multiplier, used for three partial products in turn
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				mop_a = x_q[31:0];
				mop_b = y_q[31:0];
			end
			2'd1: begin
				mop_a = x_q[31:0];
				mop_b = y_q[63:32];
			end
			default: begin
				mop_a = x_q[63:32];
				mop_b = y_q[31:0];
			end
		endcase
	end
	assign prod = {32'd0, mop_a} * {32'd0, mop_b};

	// restoring divide step
	assign trial = {rem_q, quo_q[63]} - {1'b0, div_q};

	assign q_fix = zero_q ? '1 : (neg_q_q ? (64'd0 - quo_q) : quo_q);
	assign r_fix = zero_q ? a_q : (neg_r_q ? (64'd0 - rem_q) : rem_q);

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q     <= req.a;
			y_q     <= req.b;
			a_q     <= req.a;
			quo_q   <= ua;
			rem_q   <= '0;
			div_q   <= ub;
			neg_q_q <= na ^ nb;
			neg_r_q <= na;
			zero_q  <= (req.b == 64'd0);
			is_rem_q <= (req.op == MD_REM);
		end else if (busy_q) begin
			if (is_mul_q) begin
				if (cnt_q == 7'd0) begin
					acc_q <= prod;
				end else begin
					acc_q <= acc_q + {prod[31:0], 32'd0};
				end
				if (cnt_q == 7'd2) begin
					res_q <= acc_q + {prod[31:0], 32'd0};
				end
			end else if (cnt_q == 7'd64) begin
				res_q <= is_rem_q ? r_fix : q_fix;
			end else if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			is_mul_q <= 1'b0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q   <= 1'b1;
				is_mul_q <= (req.op == MD_MUL);
				cnt_q    <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if ((is_mul_q && cnt_q == 7'd2) || (!is_mul_q && cnt_q == 7'd64)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

	`include "rv64im_execute_unit_macros.svh"
	`RV64IM_ASSERT(a_md_no_restart, busy_q |-> !req.start, "muldiv restarted while busy")
	`RV64IM_ASSERT(a_md_done_end, done_q |-> $past(busy_q) && !busy_q, "done without a run")
	`RV64IM_ASSERT(a_md_cnt_range, busy_q |-> (cnt_q <= 7'd64), "muldiv counter overran")

endmodule

/* rtl/rv64ex_alu.sv */
`timescale 1ns / 1ps
module rv64ex_alu import rv64ex_pkg::*; (
	input  in_t         item,
	input  pend_t       pend,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output exec_t       ex
);

	logic [31:0] ins;
	logic [4:0]  op, rd;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [63:0] pc, ii, is, ib, iu, ij, v, nxt, d, za, zb, a32, b32;
	logic        ok, wr, t;

	assign ins = item.instruction;
	assign pc  = item.pc;
	assign op  = ins[6:2];
	assign f3  = ins[14:12];
	assign f7  = ins[31:25];
	assign rd  = ins[11:7];
	assign ii  = {{52{ins[31]}}, ins[31:20]};
	assign is  = {{52{ins[31]}}, ins[31:25], ins[11:7]};
	assign ib  = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
	assign iu  = {{32{ins[31]}}, ins[31:12], 12'd0};
	assign ij  = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
	assign za  = {32'd0, a[31:0]};
	assign zb  = {32'd0, b[31:0]};
	assign a32 = sx32(a);
	assign b32 = sx32(b);

	// loaded data extension
	always_comb begin
		case (pend.size)
			2'd0:    d = pend.sgn ? {{56{item.load_data[7]}}, item.load_data[7:0]}
			                  : {56'd0, item.load_data[7:0]};
			2'd1:    d = pend.sgn ? {{48{item.load_data[15]}}, item.load_data[15:0]}
			                  : {48'd0, item.load_data[15:0]};
			2'd2:    d = pend.sgn ? sx32(item.load_data) : {32'd0, item.load_data[31:0]};
			default: d = item.load_data;
		endcase
	end

	// decode and execute
	always_comb begin
		ex  = '0;
		ok  = 1'b1;
		wr  = 1'b1;
		v   = '0;
		t   = 1'b0;
		nxt = pc + 64'd4;
		if (ins[1:0] != 2'b11) begin
			ok = 1'b0;
		end else begin
			case (op)
				OP_REG: begin
					if (f7 == 7'h00) begin
						case (f3)
							3'd0:    v = a + b;
							3'd1:    v = a << b[5:0];
							3'd2:    v = 64'($signed(a) < $signed(b));
							3'd3:    v = 64'(a < b);
							3'd4:    v = a ^ b;
							3'd5:    v = a >> b[5:0];
							3'd6:    v = a | b;
							default: v = a & b;
						endcase
					end else if (f7 == 7'h20 && f3 == 3'd0) begin
						v = a - b;
					end else if (f7 == 7'h20 && f3 == 3'd5) begin
						v = 64'($signed(a) >>> b[5:0]);
					end else if (f7 == 7'h01 && (f3 == 3'd0 || f3[2])) begin
						ex.md.start = 1'b1;
						ex.md.op    = (f3 == 3'd0) ? MD_MUL : (f3[1] ? MD_REM : MD_DIV);
						ex.md.sgn   = !f3[0];
						ex.md.a     = a;
						ex.md.b     = b;
					end else begin
						ok = 1'b0;
					end
				end
				OP_REG32: begin
					if (f7 == 7'h00 && f3 == 3'd0) begin
						v = sx32(a + b);
					end else if (f7 == 7'h00 && f3 == 3'd1) begin
						v = sx32(a << b[4:0]);
					end else if (f7 == 7'h00 && f3 == 3'd5) begin
						v = sx32(za >> b[4:0]);
					end else if (f7 == 7'h20 && f3 == 3'd0) begin
						v = sx32(a - b);
					end else if (f7 == 7'h20 && f3 == 3'd5) begin
						v = sx32(64'($signed(a32) >>> b[4:0]));
					end else if (f7 == 7'h01 && (f3 == 3'd0 || f3[2])) begin
						ex.md.start = 1'b1;
						ex.word     = 1'b1;
						ex.md.op    = (f3 == 3'd0) ? MD_MUL : (f3[1] ? MD_REM : MD_DIV);
						ex.md.sgn   = !f3[0];
						ex.md.a     = (f3[2] && f3[0]) ? za : a32;
						ex.md.b     = (f3[2] && f3[0]) ? zb : b32;
					end else begin
						ok = 1'b0;
					end
				end
				OP_IMM: begin
					case (f3)
						3'd0: v = a + ii;
						3'd2: v = 64'($signed(a) < $signed(ii));
						3'd3: v = 64'(a < ii);
						3'd4: v = a ^ ii;
						3'd6: v = a | ii;
						3'd7: v = a & ii;
						3'd1: begin
							if (ins[31:26] == 6'h00) v = a << ii[5:0];
							else ok = 1'b0;
						end
						default: begin
							if (ins[31:26] == 6'h00) v = a >> ii[5:0];
							else if (ins[31:26] == 6'h10) v = 64'($signed(a) >>> ii[5:0]);
							else ok = 1'b0;
						end
					endcase
				end
				OP_IMM32: begin
					if (f3 == 3'd0) v = sx32(a + ii);
					else if (f3 == 3'd1 && f7 == 7'h00) v = sx32(a << ii[4:0]);
					else if (f3 == 3'd5 && f7 == 7'h00) v = sx32(za >> ii[4:0]);
					else if (f3 == 3'd5 && f7 == 7'h20) v = sx32(64'($signed(a32) >>> ii[4:0]));
					else ok = 1'b0;
				end
				OP_LOAD: begin
					if (f3 == 3'd7) begin
						ok = 1'b0;
					end else begin
						wr                = 1'b0;
						ex.out.mem_op     = MEM_LOAD;
						ex.out.mem_addr   = a + ii;
						ex.out.mem_size   = f3[1:0];
						ex.pend_wr        = 1'b1;
						ex.pend_nxt.valid = 1'b1;
						ex.pend_nxt.dest  = rd;
						ex.pend_nxt.size  = f3[1:0];
						ex.pend_nxt.sgn   = !f3[2];
					end
				end
				OP_STORE: begin
					if (f3[2]) begin
						ok = 1'b0;
					end else begin
						wr                = 1'b0;
						ex.out.mem_op     = MEM_STORE;
						ex.out.mem_addr   = a + is;
						ex.out.mem_size   = f3[1:0];
						ex.out.store_data = b;
					end
				end
				OP_BRANCH: begin
					wr = 1'b0;
					case (f3)
						3'd0:    t = (a == b);
						3'd1:    t = (a != b);
						3'd4:    t = $signed(a) < $signed(b);
						3'd5:    t = !($signed(a) < $signed(b));
						3'd6:    t = a < b;
						3'd7:    t = a >= b;
						default: ok = 1'b0;
					endcase
					if (t) nxt = pc + ib;
				end
				OP_AUIPC: v = pc + iu;
				OP_LUI:   v = iu;
				OP_JAL: begin
					v   = pc + 64'd4;
					nxt = pc + ij;
				end
				OP_JALR: begin
					if (f3 != 3'd0) begin
						ok = 1'b0;
					end else begin
						v   = pc + 64'd4;
						nxt = (a + ii) & ~64'd1;
					end
				end
				OP_SYSTEM: begin
					if (ins == INSN_EBREAK) begin
						wr               = 1'b0;
						ex.out.status    = ST_HALT;
						ex.out.halt_code = a;
					end else begin
						ok = 1'b0;
					end
				end
				default: ok = 1'b0;
			endcase
		end

		ex.out.next_pc  = nxt;
		ex.out.wb_valid = wr;
		ex.out.wb_index = rd;
		ex.out.wb_value = v;

		if (!ok) begin
			ex                = '0;
			ex.out.next_pc    = pc + 64'd4;
			ex.out.status     = ST_ILLEGAL;
		end

		// load return overrides everything
		if (item.command) begin
			ex = '0;
			if (pend.valid) begin
				ex.out.wb_valid = 1'b1;
				ex.out.wb_index = pend.dest;
				ex.out.wb_value = d;
				ex.pend_wr      = 1'b1;
			end
		end
	end

endmodule
